FILE: rtl/height_sample_normalizer_defines.svh
// ----------------------------------------------------------------------------
// Height sample normaliser assertion macros
// Shared property wrappers on clk_i with rst_ni as disable.
// ----------------------------------------------------------------------------
`ifndef HEIGHT_SAMPLE_NORMALIZER_DEFINES_SVH
`define HEIGHT_SAMPLE_NORMALIZER_DEFINES_SVH

// Same-cycle implication.
`define HSN_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("height_sample_normalizer: same-cycle check failed");

// Next-cycle implication.
`define HSN_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("height_sample_normalizer: next-cycle check failed");

`endif

FILE: rtl/hsn_pkg.sv
// ----------------------------------------------------------------------------
// Height sample normaliser package
// Format codes and the float to 16-bit scaling function.
// ----------------------------------------------------------------------------
package hsn_pkg;

  localparam logic [1:0] FMT_U16 = 2'd0;
  localparam logic [1:0] FMT_I16 = 2'd1;
  localparam logic [1:0] FMT_F32 = 2'd2;

  localparam logic [30:0] ONE_BITS = 31'h3F80_0000;
  localparam logic [7:0]  EXP_MAX  = 8'hFF;
  // below this exponent the scaled value stays under one half
  localparam logic [7:0]  EXP_MIN  = 8'd110;
  localparam logic [8:0]  EXP_BIAS_SHIFT = 9'd150;

  // round(x * 65535) for finite x in [0, 1]: product rounded to 24 bits
  // nearest-even, then to an integer with halves away from zero.
  function automatic logic [15:0] scale_f32(logic [30:0] mag);
    logic [7:0]  expo;
    logic [23:0] sig;
    logic [39:0] prod;
    logic [23:0] q0;
    logic        rbit;
    logic        sticky;
    logic [24:0] q;
    logic [8:0]  n9;
    logic [4:0]  n;
    logic [25:0] sum;
    logic [25:0] r;
    logic [15:0] res;
    expo = mag[30:23];
    sig  = {1'b1, mag[22:0]};
    // multiply by 65535 as x*2^16 - x
    prod = {sig, 16'd0} - {16'd0, sig};
    if (prod[39]) begin
      q0     = prod[39:16];
      rbit   = prod[15];
      sticky = |prod[14:0];
    end else begin
      q0     = prod[38:15];
      rbit   = prod[14];
      sticky = |prod[13:0];
    end
    q   = {1'b0, q0} + {24'd0, (rbit && (sticky || q0[0]))};
    n9  = EXP_BIAS_SHIFT - {1'b0, expo} - (prod[39] ? 9'd16 : 9'd15);
    n   = n9[4:0];
    sum = {1'b0, q} + (26'd1 << (n - 5'd1));
    r   = sum >> n;
    if (expo < EXP_MIN) begin
      res = 16'd0;
    end else if (r > 26'h00FFFF) begin
      res = 16'hFFFF;
    end else begin
      res = r[15:0];
    end
    return res;
  endfunction

endpackage

FILE: rtl/height_sample_normalizer.sv
// ----------------------------------------------------------------------------
// Height sample normaliser
// One result per sample; a sample passes from an input register to a result
// register. Throughput is one transfer per clock while the sink does not stall;
// the float scale between the registers is combinational. The result register
// holds while the sink stalls and the input register keeps accepting until both
// are full. sample_format is to be written by the user only while no sample
// is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
`include "height_sample_normalizer_defines.svh"

module height_sample_normalizer
  import hsn_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_wdata_i,    // sample_format
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [31:0] s_tdata_i,      // [31:0] raw_word
  input  logic        s_tlast_i,      // last_sample
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [15:0] m_tdata_o,      // [15:0] height_value
  output logic [1:0]  m_tuser_o,      // [0] sample_bad, [1] run_all_valid
  output logic        m_tlast_o       // run_end
);

  logic [1:0]  fmt_q;
  logic        in_vld_q, in_vld_d;
  logic [31:0] word_q;
  logic        last_q;
  logic        out_vld_q, out_vld_d;
  logic [15:0] height_q, height_d;
  logic        bad_q, bad_d;
  logic        allv_q, allv_d;
  logic        end_q;
  logic        vsf_q, vsf_d;
  logic        s_xfer, load_out, out_free;

  assign out_free   = !out_vld_q || m_tready_i;
  assign load_out   = in_vld_q && out_free;
  assign s_tready_o = !in_vld_q || out_free;
  assign s_xfer     = s_tvalid_i && s_tready_o;

  always_comb begin
    in_vld_d  = s_xfer ? 1'b1 : (load_out ? 1'b0 : in_vld_q);
    out_vld_d = load_out ? 1'b1 : (m_tready_i ? 1'b0 : out_vld_q);
  end

  always_comb begin
    height_d = 16'd0;
    bad_d    = 1'b0;
    unique case (fmt_q)
      FMT_U16: height_d = word_q[15:0];
      FMT_I16: height_d = {~word_q[15], word_q[14:0]};
      default: begin
        // non-finite, negative non-zero, or above one
        bad_d = (word_q[30:23] == EXP_MAX) || (word_q[31] && (word_q[30:0] != 31'd0)) ||
                (word_q[30:0] > ONE_BITS);
        if (!bad_d) begin
          height_d = scale_f32(word_q[30:0]);
        end
      end
    endcase
    allv_d = vsf_q && !bad_d;
    vsf_d  = vsf_q;
    if (load_out) begin
      vsf_d = last_q ? 1'b1 : allv_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fmt_q     <= FMT_U16;
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      vsf_q     <= 1'b1;
    end else begin
      if (cfg_we_i) begin
        fmt_q <= cfg_wdata_i;
      end
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
      vsf_q     <= vsf_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_xfer) begin
      word_q <= s_tdata_i;
      last_q <= s_tlast_i;
    end
    if (load_out) begin
      height_q <= height_d;
      bad_q    <= bad_d;
      allv_q   <= allv_d;
      end_q    <= last_q;
    end
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = height_q;
  assign m_tuser_o  = {allv_q, bad_q};
  assign m_tlast_o  = end_q;

  `HSN_ASSERT_IMP(a_bad_zero, out_vld_q && bad_q, height_q == 16'd0)
  `HSN_ASSERT_IMP(a_bad_clears_run, out_vld_q && bad_q, !allv_q)
  `HSN_ASSERT_NXT(a_run_restart, load_out && last_q, vsf_q)
  `HSN_ASSERT_IMP(a_bad_only_float, out_vld_q && bad_q, fmt_q != FMT_U16 && fmt_q != FMT_I16)

endmodule
